### hw/rtl/bhpq_pkg.sv
// bhpq_pkg: types, constants and helpers for the binary heap priority queue
// used by binary_heap_priority_queue and its testbench; no dependencies
package bhpq_pkg;
   localparam int DEPTH = 64;
   localparam int RANK_BITS = 16;
   localparam int ADDR_BITS = $clog2(DEPTH + 1);
   localparam int CNT_BITS = 7;
   localparam int ENTRY_BITS = RANK_BITS + 64;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_INVERT = 2'd2;
   localparam logic [1:0] MODE_LOOKUP = 2'd3;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [15:0]        entry_rank;
      logic signed [31:0] member_id;
      logic signed [31:0] book_id;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               found;
      logic [15:0]        found_rank;
      logic               is_empty;
      logic [6:0]         entry_total;
      logic [15:0]        top_rank;
      logic signed [31:0] top_member;
      logic signed [31:0] top_book;
   } rsp_type;

   typedef struct packed {
      logic [RANK_BITS-1:0] rank;
      logic [31:0]          member;
      logic [31:0]          book;
   } entry_type;

   function automatic logic beats(input logic inv, input logic [RANK_BITS-1:0] a,
                                  input logic [RANK_BITS-1:0] b);
      return inv ? (a > b) : (a < b);
   endfunction
endpackage

### hw/rtl/binary_heap_priority_queue.sv
// binary_heap_priority_queue: heap of entries in one ram, one operation per beat
// depends on bhpq_pkg and bhpq_ram
// insert sifts up, remove moves the last entry to the root and sifts it down,
// invert flips the order and sifts every entry up, lookup scans in address order
// one item at a time; the top entry is reread from the ram to form the result beat
// reset clears count and order flag; ram contents are undefined until written
module binary_heap_priority_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  bhpq_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bhpq_pkg::rsp_type   rsp_data
);
   import bhpq_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_UPRD = 3'd1;
   localparam logic [2:0] ST_UPCMP = 3'd2;
   localparam logic [2:0] ST_DNRD = 3'd3;
   localparam logic [2:0] ST_DNCMP = 3'd4;
   localparam logic [2:0] ST_LKRD = 3'd5;
   localparam logic [2:0] ST_LKCMP = 3'd6;
   localparam logic [2:0] ST_DONE = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  inv_ff, inv_in;
   logic [ADDR_BITS-1:0]  pos_ff, pos_in;
   logic [ADDR_BITS-1:0]  iter_ff, iter_in;
   logic                  invert_ff, invert_in;
   entry_type             mov_ff, mov_in;
   req_type               req_ff, req_in;
   logic [1:0]            status_ff, status_in;
   logic                  found_ff, found_in;
   logic [15:0]           frank_ff, frank_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr, rd_a, rd_b;
   entry_type             wr_data, rdata_a, rdata_b;

   bhpq_ram #(.WIDTH(ENTRY_BITS), .DEPTH(2 ** ADDR_BITS)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr_a(rd_a), .rd_data_a(rdata_a), .rd_addr_b(rd_b), .rd_data_b(rdata_b)
   );

   logic accept;
   logic [ADDR_BITS:0] lft, rgt;
   logic [ADDR_BITS-1:0] pick;
   entry_type pick_e;
   logic rgt_ok;
   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign lft = {pos_ff, 1'b0};
   assign rgt = {pos_ff, 1'b1};
   assign rgt_ok = ({1'b0, rgt} <= (ADDR_BITS + 2)'(count_ff)) &&
                   beats(inv_ff, rdata_b.rank, rdata_a.rank);
   assign pick = rgt_ok ? rgt[ADDR_BITS-1:0] : lft[ADDR_BITS-1:0];
   assign pick_e = rgt_ok ? rdata_b : rdata_a;

   always_comb begin
      state_in = state_ff; count_in = count_ff; inv_in = inv_ff; pos_in = pos_ff;
      iter_in = iter_ff; invert_in = invert_ff; mov_in = mov_ff; req_in = req_ff;
      status_in = status_ff; found_in = found_ff; frank_in = frank_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall; rsp_in = rsp_ff;
      wr_en = 1'b0; wr_addr = pos_ff; wr_data = mov_ff;
      rd_a = pos_ff; rd_b = pos_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data; status_in = STATUS_DONE; found_in = 1'b0;
               frank_in = '0; invert_in = 1'b0;
               unique case (req_data.mode)
                  MODE_INSERT: begin
                     if (count_ff >= CNT_BITS'(DEPTH)) begin
                        status_in = STATUS_FULL; state_in = ST_DONE;
                     end else begin
                        count_in = count_ff + 1'b1;
                        pos_in = ADDR_BITS'(count_ff + 1'b1);
                        mov_in.rank = req_data.entry_rank[RANK_BITS-1:0];
                        mov_in.member = req_data.member_id;
                        mov_in.book = req_data.book_id;
                        rd_a = ADDR_BITS'((count_ff + 1'b1) >> 1);
                        state_in = ST_UPCMP;
                     end
                  end
                  MODE_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY; state_in = ST_DONE;
                     end else begin
                        rd_a = ADDR_BITS'(count_ff);
                        count_in = count_ff - 1'b1;
                        pos_in = ADDR_BITS'(1);
                        state_in = ST_DNRD;
                     end
                  end
                  MODE_INVERT: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY; state_in = ST_DONE;
                     end else begin
                        inv_in = !inv_ff; invert_in = 1'b1;
                        iter_in = ADDR_BITS'(1); pos_in = ADDR_BITS'(1);
                        rd_a = ADDR_BITS'(1);
                        state_in = ST_UPRD;
                     end
                  end
                  default: begin
                     iter_in = ADDR_BITS'(1); rd_a = ADDR_BITS'(1);
                     state_in = (count_ff == '0) ? ST_DONE : ST_LKCMP;
                  end
               endcase
            end
         end
         ST_UPRD: begin
            // moving entry just read at pos; fetch its parent
            mov_in = rdata_a;
            rd_a = pos_ff >> 1;
            state_in = ST_UPCMP;
         end
         ST_UPCMP: begin
            if (pos_ff > ADDR_BITS'(1) && beats(inv_ff, mov_ff.rank, rdata_a.rank)) begin
               wr_en = 1'b1; wr_addr = pos_ff; wr_data = rdata_a;
               pos_in = pos_ff >> 1;
               rd_a = pos_ff >> 2;
            end else begin
               wr_en = 1'b1; wr_addr = pos_ff; wr_data = mov_ff;
               if (invert_ff && iter_ff < ADDR_BITS'(count_ff)) begin
                  iter_in = iter_ff + 1'b1; pos_in = iter_ff + 1'b1;
                  rd_a = iter_ff + 1'b1;
                  state_in = ST_UPRD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DNRD: begin
            mov_in = rdata_a;
            rd_a = lft[ADDR_BITS-1:0]; rd_b = rgt[ADDR_BITS-1:0];
            state_in = ST_DNCMP;
         end
         ST_DNCMP: begin
            if (lft <= (ADDR_BITS + 1)'(count_ff) && beats(inv_ff, pick_e.rank, mov_ff.rank))
            begin
               wr_en = 1'b1; wr_addr = pos_ff; wr_data = pick_e;
               pos_in = pick;
               rd_a = ADDR_BITS'({pick, 1'b0}); rd_b = ADDR_BITS'({pick, 1'b1});
            end else begin
               wr_en = 1'b1; wr_addr = pos_ff; wr_data = mov_ff;
               state_in = ST_DONE;
            end
         end
         ST_LKCMP: begin
            if (rdata_a.member == req_ff.member_id && rdata_a.book == req_ff.book_id) begin
               found_in = 1'b1; frank_in = 16'(rdata_a.rank);
               state_in = ST_DONE;
            end else if (iter_ff >= ADDR_BITS'(count_ff)) begin
               state_in = ST_DONE;
            end else begin
               iter_in = iter_ff + 1'b1; rd_a = iter_ff + 1'b1;
            end
         end
         ST_DONE: begin
            rd_a = ADDR_BITS'(1);
            state_in = ST_LKRD;
         end
         ST_LKRD: begin
            rsp_valid_in = 1'b1;
            rsp_in.status = status_ff; rsp_in.found = found_ff;
            rsp_in.found_rank = frank_ff;
            rsp_in.is_empty = (count_ff == '0);
            rsp_in.entry_total = count_ff;
            rsp_in.top_rank = (count_ff == '0) ? '0 : 16'(rdata_a.rank);
            rsp_in.top_member = (count_ff == '0) ? '0 : rdata_a.member;
            rsp_in.top_book = (count_ff == '0) ? '0 : rdata_a.book;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; count_ff <= '0; inv_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; inv_ff <= inv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff <= pos_in; iter_ff <= iter_in; invert_ff <= invert_in; mov_ff <= mov_in;
      req_ff <= req_in; status_ff <= status_in; found_ff <= found_in;
      frank_ff <= frank_in; rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH)) else $error("count overflow");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall) else $error("accept while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("response dropped");
endmodule

### hw/rtl/bhpq_ram.sv
// bhpq_ram: generic single-port-write, dual-port-read ram with registered reads
// depends on nothing
module bhpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end
endmodule

### tb/tb_binary_heap_priority_queue.sv
// tb_binary_heap_priority_queue: random and directed test of the heap priority queue
// depends on bhpq_pkg and binary_heap_priority_queue; predicts each result beat in-line
module tb_binary_heap_priority_queue;
   timeunit 1ns;
   timeprecision 1ps;
   import bhpq_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   binary_heap_priority_queue i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   entry_type heap_copy [1:DEPTH];
   int        heap_size = 0;
   logic      flipped = 1'b0;
   req_type   pending_reqs [$];
   rsp_type   expected_rsps [$];
   int        mismatches = 0;
   int        beats_checked = 0;
   int        cycles = 0;
   int        req_gap = 0;
   int        rsp_gap = 0;
   bit        stim_done = 1'b0;
   int        n_full = 0, n_empty = 0, n_found = 0;

   function automatic bit wins(logic [RANK_BITS-1:0] a, logic [RANK_BITS-1:0] b);
      return flipped ? (a > b) : (a < b);
   endfunction

   function automatic void swap_entries(int x, int y);
      entry_type t;
      t = heap_copy[x];
      heap_copy[x] = heap_copy[y];
      heap_copy[y] = t;
   endfunction

   function automatic void bubble_up(int p);
      while (p > 1 && wins(heap_copy[p].rank, heap_copy[p/2].rank)) begin
         swap_entries(p, p / 2);
         p = p / 2;
      end
   endfunction

   function automatic void bubble_down();
      int p, l, pick;
      p = 1;
      forever begin
         l = 2 * p;
         if (l > heap_size) break;
         pick = l;
         if (l + 1 <= heap_size && wins(heap_copy[l+1].rank, heap_copy[l].rank))
            pick = l + 1;
         if (!wins(heap_copy[pick].rank, heap_copy[p].rank)) break;
         swap_entries(p, pick);
         p = pick;
      end
   endfunction

   function automatic rsp_type heap_apply(req_type r);
      rsp_type o;
      o = '0;
      case (r.mode)
         MODE_INSERT: begin
            if (heap_size >= DEPTH) o.status = STATUS_FULL;
            else begin
               heap_size++;
               heap_copy[heap_size] = '{r.entry_rank, r.member_id, r.book_id};
               bubble_up(heap_size);
            end
         end
         MODE_REMOVE: begin
            if (heap_size == 0) o.status = STATUS_EMPTY;
            else begin
               heap_copy[1] = heap_copy[heap_size];
               heap_size--;
               bubble_down();
            end
         end
         MODE_INVERT: begin
            if (heap_size == 0) o.status = STATUS_EMPTY;
            else begin
               flipped = !flipped;
               for (int i = 1; i <= heap_size; i++) bubble_up(i);
            end
         end
         default: begin
            for (int i = 1; i <= heap_size; i++)
               if (heap_copy[i].member == r.member_id && heap_copy[i].book == r.book_id) begin
                  o.found = 1'b1;
                  o.found_rank = heap_copy[i].rank;
                  break;
               end
         end
      endcase
      o.is_empty = (heap_size == 0);
      o.entry_total = heap_size[6:0];
      if (heap_size > 0) begin
         o.top_rank = heap_copy[1].rank;
         o.top_member = heap_copy[1].member;
         o.top_book = heap_copy[1].book;
      end
      return o;
   endfunction

   function automatic int pick_gap();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_type make_req(logic [1:0] m, int rk, int mem, int bk);
      req_type r;
      r.mode = m;
      r.entry_rank = 16'(rk);
      r.member_id = mem;
      r.book_id = bk;
      return r;
   endfunction

   // small id pools so lookups hit; wide values now and then for bit coverage
   function automatic int rand_id();
      return ($urandom_range(0, 4) == 0) ? int'($urandom) : int'($urandom_range(0, 7));
   endfunction

   function automatic logic [15:0] rand_rank();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 7));
         1: return 16'hFFFF - 16'($urandom_range(0, 7));
         default: return 16'($urandom);
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_stall) begin
      end else if (req_gap > 0) begin
         req_gap <= req_gap - 1;
         req_valid <= 1'b0;
      end else if ((!req_valid || !req_stall) && pending_reqs.size() > 0 &&
                   !(req_valid && pending_reqs.size() == 0)) begin
         req_type r;
         r = pending_reqs.pop_front();
         expected_rsps.push_back(heap_apply(r));
         req_data <= r;
         req_valid <= 1'b1;
         req_gap <= pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected beat %p", rsp_data);
            end else begin
               rsp_type e;
               e = expected_rsps.pop_front();
               beats_checked++;
               if (e.status == STATUS_FULL) n_full++;
               if (e.status == STATUS_EMPTY) n_empty++;
               if (e.found) n_found++;
               if (rsp_data !== e) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("beat %0d: expected %p got %p", beats_checked, e, rsp_data);
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_gap <= pick_gap();
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int mem, bk, fill;
      // directed: empty corner cases, extremes, invert, lookups
      pending_reqs.push_back(make_req(MODE_REMOVE, 0, 0, 0));
      pending_reqs.push_back(make_req(MODE_INVERT, 0, 0, 0));
      pending_reqs.push_back(make_req(MODE_LOOKUP, 0, 0, 0));
      pending_reqs.push_back(make_req(MODE_INSERT, 16'hFFFF, 32'h7FFFFFFF, 32'h80000000));
      pending_reqs.push_back(make_req(MODE_INSERT, 16'h0000, 32'h80000000, 32'h7FFFFFFF));
      pending_reqs.push_back(make_req(MODE_INSERT, 16'h0000, -1, -1));
      pending_reqs.push_back(make_req(MODE_LOOKUP, 0, -1, -1));
      pending_reqs.push_back(make_req(MODE_LOOKUP, 0, -1, 0));
      pending_reqs.push_back(make_req(MODE_INVERT, 0, 0, 0));
      pending_reqs.push_back(make_req(MODE_REMOVE, 0, 0, 0));
      pending_reqs.push_back(make_req(MODE_INVERT, 0, 0, 0));
      pending_reqs.push_back(make_req(MODE_REMOVE, 0, 0, 0));
      pending_reqs.push_back(make_req(MODE_REMOVE, 0, 0, 0));
      pending_reqs.push_back(make_req(MODE_REMOVE, 0, 0, 0));
      // random: phases of filling and draining so full and empty both recur
      fill = 1;
      for (int n = 0; n < 750; n++) begin
         int k;
         k = $urandom_range(0, 99);
         if ($urandom_range(0, 59) == 0) fill = !fill;
         mem = rand_id();
         bk = rand_id();
         if (k < (fill ? 60 : 20))
            pending_reqs.push_back(make_req(MODE_INSERT, rand_rank(), mem, bk));
         else if (k < 80)
            pending_reqs.push_back(make_req(MODE_REMOVE, $urandom, mem, bk));
         else if (k < 85)
            pending_reqs.push_back(make_req(MODE_INVERT, $urandom, mem, bk));
         else
            pending_reqs.push_back(make_req(MODE_LOOKUP, $urandom, mem, bk));
      end
      stim_done = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      wait (stim_done && !reset);
      while ((pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_valid) &&
             cycles < 2000000)
         @(posedge clock);
      if (cycles >= 2000000) begin
         $display("Mismatches found");
         $finish;
      end else begin
         repeat (300) @(posedge clock);
         $display("checked %0d beats: %0d full drops, %0d empty ops, %0d lookup hits",
                  beats_checked, n_full, n_empty, n_found);
         if (mismatches == 0) $display("No mismatches found");
         else $display("Mismatches found");
         $finish;
      end
   end
endmodule
